// File: rtl/bss_pkg.sv
// ---------------------------------------------------------------------------
// bss_pkg: shared types for the bounded stack with search
// Beat formats, operation and status codes, controller state, and the
// command and status groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned POS_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_SCAN
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] code;
    logic        [31:0] weight;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_code;
    logic        [31:0] out_weight;
    logic [POS_W-1:0]   position;
    logic               is_full;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic    capture;    // latch the accepted input beat
    logic    push_wr;    // write the held record at the top and grow the stack
    logic    pop;        // shrink the stack by one
    logic    rd_top;     // read the top entry
    logic    scan_step;  // read the entry below the one last read
    logic    load_out;   // load the output register
    status_e res_status;
    logic    res_record; // result carries the last read record
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic match;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/bss_ctrl.sv
// ---------------------------------------------------------------------------
// bss_ctrl: operation sequencer
// Takes one beat at a time, decides the outcome of push, pop and peek, and
// steps a search down the stack one entry per cycle.
// ---------------------------------------------------------------------------
module bss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output bss_pkg::cmd_t cmd_o,
  input  bss_pkg::sts_t sts_i
);
  import bss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    in_stall_o       = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.op == OP_PUSH) begin
          if (sts_i.out_free) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.res_status = sts_i.full ? ST_FULL : ST_OK;
            cmd_o.push_wr    = !sts_i.full;
            state_d          = S_IDLE;
          end
        end else if (sts_i.empty) begin
          if (sts_i.out_free) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.res_status = ST_EMPTY;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = (sts_i.op == OP_SEARCH) ? S_SCAN : S_READ;
        end
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.res_record = 1'b1;
          cmd_o.pop        = (sts_i.op == OP_POP);
          state_d          = S_IDLE;
        end
      end
      S_SCAN: begin
        // The read data always belongs to the entry at the scan pointer.
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.res_record = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (sts_i.ptr_zero) begin
          if (sts_i.out_free) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.res_status = ST_MISSING;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bss_datapath.sv
// ---------------------------------------------------------------------------
// bss_datapath: record store, fill count and output register
// Holds the stack in a single-port memory with a registered read, the held
// input beat, the scan pointer and the result register.
// ---------------------------------------------------------------------------
module bss_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bss_pkg::in_t  in_data_i,
  input  bss_pkg::cmd_t cmd_i,
  output bss_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bss_pkg::out_t out_data_o
);
  import bss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [63:0]   mem_q [DEPTH];
  logic [63:0]   rd_data_q;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] top_addr;
  logic          rd_en;
  in_t           hold_q;
  out_t          out_q;
  logic          out_valid_q;
  logic [AW:0]   pos_wide;

  assign top_addr = AW'(count_q - CW'(1));
  assign rd_en    = cmd_i.rd_top | cmd_i.scan_step;
  assign rd_addr_d = cmd_i.rd_top ? top_addr : (rd_addr_q - AW'(1));

  always_comb begin
    count_d = count_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      mem_q[AW'(count_q)] <= {hold_q.code, hold_q.weight};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr_d];
      rd_addr_q <= rd_addr_d;
    end
    if (cmd_i.capture) begin
      hold_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign pos_wide = {1'b0, rd_addr_q} + (AW + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status     <= cmd_i.res_status;
      out_q.out_code   <= cmd_i.res_record ? rd_data_q[63:32] : '0;
      out_q.out_weight <= cmd_i.res_record ? rd_data_q[31:0] : '0;
      out_q.position   <= cmd_i.res_record ? POS_W'(pos_wide) : '0;
      out_q.is_full    <= (count_d == CW'(DEPTH));
      out_q.is_empty   <= (count_d == '0);
    end
  end

  assign sts_o.op       = hold_q.operation;
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.match    = (rd_data_q[63:32] == hold_q.code);
  assign sts_o.ptr_zero = (rd_addr_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !sts_o.full)
    else $error("push written into a full stack");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !sts_o.empty)
    else $error("pop from an empty stack");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> sts_o.out_free)
    else $error("result overwrote a beat still waiting at the output");

endmodule

// File: rtl/bounded_stack_with_search.sv
// ---------------------------------------------------------------------------
// bounded_stack_with_search: bounded LIFO stack of records with search
// Push, pop, peek and search-by-code on a stack of DEPTH code/weight records.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | bss_pkg::in_t  (op, code, weight)
//  out     | output    | out_valid_o/out_stall_i | bss_pkg::out_t (status, record, flags)
//
// One beat is in work at a time. Push and the empty/full outcomes are decided in
// the dispatch state after acceptance, pop and peek after the top entry is read,
// and a search after reading entries downward from the top, one memory read per cycle.
// A finished result sits in the output register; the next beat is accepted
// while it waits, and the block holds before loading a new result until the
// output side takes the old one. Reset clears the fill count and output valid.
module bounded_stack_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bss_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bss_pkg::out_t out_data_o
);
  import bss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
